FILE: rtl/core/hsvc_pkg.sv
package hsvc_pkg;

    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned HNUM_W     = 12;
    localparam int unsigned SAT_RCP_W  = 20;
    localparam int unsigned HUE_RCP_W  = 17;
    localparam int unsigned FRAC_W     = 12;
    localparam int unsigned SPROD_W    = CHAN_W + SAT_RCP_W;
    localparam int unsigned HPROD_W    = HNUM_W + HUE_RCP_W + 1;
    localparam int unsigned SSUM_W     = SPROD_W + 1;
    localparam int unsigned HSUM_W     = HPROD_W + 1;
    localparam int unsigned SSH_W      = SSUM_W - FRAC_W;
    localparam int unsigned HSH_W      = HSUM_W - FRAC_W;
    localparam int unsigned ROM_DEPTH  = 256;

    localparam int unsigned SAT_SCALE  = 255 * 4096;
    localparam int unsigned HUE_SCALE  = 180 * 4096;
    localparam int unsigned ROUND_HALF = 'h800;
    localparam int unsigned HUE_WRAP   = 180;
    localparam int unsigned HUE_TOP    = 179;
    localparam int unsigned SAT_TOP    = 255;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned NUM_CFG    = 6;
    localparam logic [CFG_DATA_W-1:0] CFG_RESET = 16'h00FF;

    localparam logic [CFG_IDX_W-1:0] REG_GREEN_HUE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_SAT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_VAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BROWN_HUE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BROWN_SAT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BROWN_VAL = 3'd5;

    typedef logic [CHAN_W-1:0] t_chan;

    // inclusive range test, min in the low byte and max in the high byte
    function automatic logic in_bounds(input t_chan x, input logic [CFG_DATA_W-1:0] bounds);
        return (x >= bounds[CHAN_W-1:0]) && (x <= bounds[CFG_DATA_W-1:CHAN_W]);
    endfunction

endpackage

FILE: rtl/core/hsvc_recip_rom.sv
module hsvc_recip_rom
    import hsvc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  t_chan                i_val,
    input  t_chan                i_diff,
    output logic [SAT_RCP_W-1:0] o_sat_rcp,
    output logic [HUE_RCP_W-1:0] o_hue_rcp
);

    logic [SAT_RCP_W-1:0] w_sat_tab [ROM_DEPTH];
    logic [HUE_RCP_W-1:0] w_hue_tab [ROM_DEPTH];
    logic [SAT_RCP_W-1:0] r_sat_rcp;
    logic [HUE_RCP_W-1:0] r_hue_rcp;

    // rounded 12-bit fraction reciprocals, entry 0 reads as zero
    for (genvar Gk = 0; Gk < ROM_DEPTH; Gk++) begin : g_tab
        localparam int unsigned Div      = (Gk == 0) ? 1 : Gk;
        localparam int unsigned SatEntry = (Gk == 0) ? 0 : (SAT_SCALE + Gk / 2) / Div;
        localparam int unsigned HueEntry = (Gk == 0) ? 0 : (HUE_SCALE + 3 * Gk) / (6 * Div);
        assign w_sat_tab[Gk] = SAT_RCP_W'(SatEntry);
        assign w_hue_tab[Gk] = HUE_RCP_W'(HueEntry);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat_rcp <= w_sat_tab[i_val];
            r_hue_rcp <= w_hue_tab[i_diff];
        end
    end

    assign o_sat_rcp = r_sat_rcp;
    assign o_hue_rcp = r_hue_rcp;

endmodule

FILE: rtl/core/hsv_color_range_classifier_core.sv
// HSV color range classifier.
// Input channel (i_in_valid / o_in_ready) takes one pixel word (blue, green and
// red bytes) per cycle while ready. Output channel (o_out_valid / i_out_ready)
// returns one word per pixel: hue 0..179, saturation, brightness (max channel)
// and a mask bit set when the pixel falls inside the green box or the brown box.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes the six
// 16-bit bound registers; index 6 and 7 are dropped. Write only while idle.
// Pipeline: five register stages (max/min/diff, reciprocal ROM read, multiply,
// round and wrap, range compare); a pixel accepted at the input passes through
// them in that order to the output. Throughput is one pixel per cycle while the
// receiver does not stall, set by the fully pipelined datapath.
// When the receiver stalls, each stage holds only if the stage ahead is full,
// so bubbles collapse and the input keeps accepting until every stage holds a
// word; nothing is dropped or repeated.
// Reset (synchronous, active low) empties the pipeline and loads 0x00FF into
// all bound registers, an empty range, so no pixel is flagged until written.
module hsv_color_range_classifier_core
    import hsvc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CHAN_W-1:0]     i_blue_level,
    input  logic [CHAN_W-1:0]     i_green_level,
    input  logic [CHAN_W-1:0]     i_red_level,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CHAN_W-1:0]     o_hue,
    output logic [CHAN_W-1:0]     o_saturation,
    output logic [CHAN_W-1:0]     o_brightness,
    output logic                  o_in_mask,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CFG_DATA_W-1:0] r_cfg [NUM_CFG];

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;

    // stage 1
    t_chan                     n_val, n_min, n_diff;
    logic signed [HNUM_W-1:0]  n_hnum;
    t_chan                     r1_val, r1_diff;
    logic signed [HNUM_W-1:0]  r1_hnum;
    // stage 2
    t_chan                     r2_val, r2_diff;
    logic signed [HNUM_W-1:0]  r2_hnum;
    logic [SAT_RCP_W-1:0]      w_sat_rcp;
    logic [HUE_RCP_W-1:0]      w_hue_rcp;
    // stage 3
    logic [SPROD_W-1:0]        r3_sprod;
    logic signed [HPROD_W-1:0] r3_hprod;
    t_chan                     r3_val;
    // stage 4
    logic [SSUM_W-1:0]         n_ssum;
    logic [SSH_W-1:0]          n_ssh;
    logic signed [HSUM_W-1:0]  n_hsum;
    logic signed [HSH_W-1:0]   n_hsh, n_hadj;
    t_chan                     n_sat, n_hue;
    t_chan                     r4_hue, r4_sat, r4_val;
    // stage 5
    logic                      n_mask;
    t_chan                     r_hue, r_sat, r_val;
    logic                      r_mask;

    // config port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CFG; k++) begin
                r_cfg[k] <= CFG_RESET;
            end
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(NUM_CFG))) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // a stage advances when empty or when the stage ahead advances
    assign w_rdy5     = !r_v5 || i_out_ready;
    assign w_rdy4     = !r_v4 || w_rdy5;
    assign w_rdy3     = !r_v3 || w_rdy4;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_in_ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_in_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
            if (w_rdy5) r_v5 <= r_v4;
        end
    end

    // stage 1: max, min, diff and hue numerator, red wins ties then green
    always_comb begin
        n_val = i_red_level;
        if (i_green_level > n_val) n_val = i_green_level;
        if (i_blue_level > n_val)  n_val = i_blue_level;
        n_min = i_red_level;
        if (i_green_level < n_min) n_min = i_green_level;
        if (i_blue_level < n_min)  n_min = i_blue_level;
        n_diff = n_val - n_min;
        if (n_val == i_red_level) begin
            n_hnum = $signed({4'b0, i_green_level}) - $signed({4'b0, i_blue_level});
        end else if (n_val == i_green_level) begin
            n_hnum = $signed({4'b0, i_blue_level}) - $signed({4'b0, i_red_level})
                   + $signed({3'b0, n_diff, 1'b0});
        end else begin
            n_hnum = $signed({4'b0, i_red_level}) - $signed({4'b0, i_green_level})
                   + $signed({2'b0, n_diff, 2'b0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_val  <= n_val;
            r1_diff <= n_diff;
            r1_hnum <= n_hnum;
        end
    end

    // stage 2: reciprocal lookups
    hsvc_recip_rom u_rom (
        .i_clk     (i_clk),
        .i_en      (w_rdy2),
        .i_val     (r1_val),
        .i_diff    (r1_diff),
        .o_sat_rcp (w_sat_rcp),
        .o_hue_rcp (w_hue_rcp)
    );

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r2_val  <= r1_val;
            r2_diff <= r1_diff;
            r2_hnum <= r1_hnum;
        end
    end

    // stage 3: products
    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r3_sprod <= SPROD_W'(r2_diff) * SPROD_W'(w_sat_rcp);
            r3_hprod <= HPROD_W'(r2_hnum) * $signed({{(HPROD_W-HUE_RCP_W){1'b0}}, w_hue_rcp});
            r3_val   <= r2_val;
        end
    end

    // stage 4: round, floor shift, wrap and clamp
    always_comb begin
        n_ssum = SSUM_W'(r3_sprod) + SSUM_W'(ROUND_HALF);
        n_ssh  = n_ssum[SSUM_W-1:FRAC_W];
        n_sat  = (n_ssh > SSH_W'(SAT_TOP)) ? CHAN_W'(SAT_TOP) : n_ssh[CHAN_W-1:0];

        n_hsum = HSUM_W'(r3_hprod) + $signed(HSUM_W'(ROUND_HALF));
        n_hsh  = n_hsum[HSUM_W-1:FRAC_W];
        n_hadj = (n_hsh < 0) ? n_hsh + $signed(HSH_W'(HUE_WRAP)) : n_hsh;
        if (n_hadj < 0) begin
            n_hue = '0;
        end else if (n_hadj > $signed(HSH_W'(HUE_TOP))) begin
            n_hue = CHAN_W'(HUE_TOP);
        end else begin
            n_hue = n_hadj[CHAN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r4_hue <= n_hue;
            r4_sat <= n_sat;
            r4_val <= r3_val;
        end
    end

    // stage 5: box tests
    assign n_mask = (in_bounds(r4_hue, r_cfg[REG_GREEN_HUE])
                    && in_bounds(r4_sat, r_cfg[REG_GREEN_SAT])
                    && in_bounds(r4_val, r_cfg[REG_GREEN_VAL]))
                 || (in_bounds(r4_hue, r_cfg[REG_BROWN_HUE])
                    && in_bounds(r4_sat, r_cfg[REG_BROWN_SAT])
                    && in_bounds(r4_val, r_cfg[REG_BROWN_VAL]));

    always_ff @(posedge i_clk) begin
        if (w_rdy5) begin
            r_hue  <= r4_hue;
            r_sat  <= r4_sat;
            r_val  <= r4_val;
            r_mask <= n_mask;
        end
    end

    assign o_out_valid  = r_v5;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_val;
    assign o_in_mask    = r_mask;

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_hue <= CHAN_W'(HUE_TOP)))
        else $error("hue above top of range");

    a_black_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_brightness == '0)) |-> ((o_saturation == '0) && (o_hue == '0)))
        else $error("black pixel with nonzero hue or saturation");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_v1)
        else $error("accepted word missing from first stage");

    a_stall_holds_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && r_v5 && !i_out_ready) |=> (r_v4 && r_v5))
        else $error("stalled word lost in tail stages");

endmodule

FILE: bench/hsv_color_range_classifier_core_tb.sv
`timescale 1ns / 100ps

module hsv_color_range_classifier_core_tb;
    import hsvc_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RESET_LEN   = 6;
    localparam int PIPE_SLACK  = 12;
    localparam int CYCLE_LIMIT = 200000;

    // indexes past the last bound register, writes there are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(NUM_CFG);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(NUM_CFG + 1);

    typedef struct packed {
        t_chan hue;
        t_chan saturation;
        t_chan brightness;
        logic  in_mask;
    } t_hsv_word;

    class hsv_mask_tracker;
        logic [CFG_DATA_W-1:0] box_bounds [NUM_CFG];
        t_hsv_word             expected_hsv_q [$];
        int                    mismatches;

        function new();
            foreach (box_bounds[i]) box_bounds[i] = CFG_RESET;
            mismatches = 0;
        endfunction

        function void set_bounds(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
            if (int'(idx) < NUM_CFG) box_bounds[idx] = data;
        endfunction

        function bit within_bounds(input int x, input logic [CFG_DATA_W-1:0] bnd);
            int lo;
            int hi;
            lo = int'(bnd[CHAN_W-1:0]);
            hi = int'(bnd[CFG_DATA_W-1:CHAN_W]);
            return (x >= lo) && (x <= hi);
        endfunction

        function t_hsv_word classify_pixel(input t_chan b, input t_chan g, input t_chan r);
            t_hsv_word w;
            int        bi, gi, ri;
            int        vmax, vmin, diff;
            int        sat_rcp, hue_rcp, hnum, s, h;
            bit        green_hit, brown_hit;
            bi = int'(b);
            gi = int'(g);
            ri = int'(r);
            vmax = ri;
            if (gi > vmax) vmax = gi;
            if (bi > vmax) vmax = bi;
            vmin = ri;
            if (gi < vmin) vmin = gi;
            if (bi < vmin) vmin = bi;
            diff = vmax - vmin;
            sat_rcp = (vmax == 0) ? 0 : (int'(SAT_SCALE) + (vmax >> 1)) / vmax;
            hue_rcp = (diff == 0) ? 0 : (int'(HUE_SCALE) + 3 * diff) / (6 * diff);

            s = (diff * sat_rcp + int'(ROUND_HALF)) >>> FRAC_W;
            if (s > int'(SAT_TOP)) s = int'(SAT_TOP);
            if (s < 0) s = 0;

            // red wins ties, then green
            if (vmax == ri) hnum = gi - bi;
            else if (vmax == gi) hnum = (bi - ri) + 2 * diff;
            else hnum = (ri - gi) + 4 * diff;
            h = (hnum * hue_rcp + int'(ROUND_HALF)) >>> FRAC_W;
            if (h < 0) h += int'(HUE_WRAP);
            if (h < 0) h = 0;
            if (h > int'(HUE_TOP)) h = int'(HUE_TOP);

            green_hit = within_bounds(h, box_bounds[REG_GREEN_HUE])
                     && within_bounds(s, box_bounds[REG_GREEN_SAT])
                     && within_bounds(vmax, box_bounds[REG_GREEN_VAL]);
            brown_hit = within_bounds(h, box_bounds[REG_BROWN_HUE])
                     && within_bounds(s, box_bounds[REG_BROWN_SAT])
                     && within_bounds(vmax, box_bounds[REG_BROWN_VAL]);

            w.hue        = t_chan'(h);
            w.saturation = t_chan'(s);
            w.brightness = t_chan'(vmax);
            w.in_mask    = green_hit || brown_hit;
            return w;
        endfunction

        function void note_pixel(input t_chan b, input t_chan g, input t_chan r);
            expected_hsv_q.push_back(classify_pixel(b, g, r));
        endfunction

        task report_mismatch(input string msg);
            mismatches++;
            $display("MISMATCH: %s", msg);
        endtask

        task check_word(input t_chan h, input t_chan s, input t_chan v, input logic m);
            t_hsv_word want;
            if (expected_hsv_q.size() == 0) begin
                report_mismatch($sformatf("word h=%0d s=%0d v=%0d m=%0b with none expected",
                                          h, s, v, m));
            end else begin
                want = expected_hsv_q.pop_front();
                if (h !== want.hue)
                    report_mismatch($sformatf("hue got %0d want %0d", h, want.hue));
                if (s !== want.saturation)
                    report_mismatch($sformatf("saturation got %0d want %0d",
                                              s, want.saturation));
                if (v !== want.brightness)
                    report_mismatch($sformatf("brightness got %0d want %0d",
                                              v, want.brightness));
                if (m !== want.in_mask)
                    report_mismatch($sformatf("in_mask got %0b want %0b", m, want.in_mask));
            end
        endtask

        function int words_pending();
            return expected_hsv_q.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [CHAN_W-1:0]     i_blue_level;
    logic [CHAN_W-1:0]     i_green_level;
    logic [CHAN_W-1:0]     i_red_level;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [CHAN_W-1:0]     o_hue;
    logic [CHAN_W-1:0]     o_saturation;
    logic [CHAN_W-1:0]     o_brightness;
    logic                  o_in_mask;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    hsv_mask_tracker tracker;
    bit              idling;
    int              stall_left;
    int              cycle_count;

    hsv_color_range_classifier_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_blue_level  (i_blue_level),
        .i_green_level (i_green_level),
        .i_red_level   (i_red_level),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_hue         (o_hue),
        .o_saturation  (o_saturation),
        .o_brightness  (o_brightness),
        .o_in_mask     (o_in_mask),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver side: random stall bursts while idling is on
    always @(posedge i_clk) begin
        if (!idling) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 3);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                tracker.note_pixel(i_blue_level, i_green_level, i_red_level);
            if (o_out_valid && i_out_ready)
                tracker.check_word(o_hue, o_saturation, o_brightness, o_in_mask);
        end
    end

    task automatic send_pixel(input t_chan b, input t_chan g, input t_chan r);
        int gap;
        if (idling && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_blue_level  <= b;
        i_green_level <= g;
        i_red_level   <= r;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.words_pending() != 0);
        repeat (PIPE_SLACK) @(posedge i_clk);
    endtask

    // valid stays high across back-to-back writes, load_boxes drops it
    task automatic write_bound(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_bounds(idx, data);
    endtask

    task automatic load_boxes(input logic [CFG_DATA_W-1:0] gh, input logic [CFG_DATA_W-1:0] gs,
                              input logic [CFG_DATA_W-1:0] gv, input logic [CFG_DATA_W-1:0] bh,
                              input logic [CFG_DATA_W-1:0] bs, input logic [CFG_DATA_W-1:0] bv);
        write_bound(REG_GREEN_HUE, gh);
        write_bound(REG_GREEN_SAT, gs);
        write_bound(REG_GREEN_VAL, gv);
        write_bound(REG_BROWN_HUE, bh);
        write_bound(REG_BROWN_SAT, bs);
        write_bound(REG_BROWN_VAL, bv);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly ordered min/max pairs, sometimes raw bits which may be inverted
    function automatic logic [CFG_DATA_W-1:0] random_bounds(input int top);
        int lo;
        int hi;
        if ($urandom_range(0, 5) == 0) return CFG_DATA_W'($urandom_range(0, 16'hFFFF));
        lo = $urandom_range(0, top);
        hi = $urandom_range(lo, 255);
        return {t_chan'(hi), t_chan'(lo)};
    endfunction

    task automatic load_random_boxes();
        write_bound(REG_SPARE_LO, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
        write_bound(REG_SPARE_HI, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
        load_boxes(random_bounds(int'(HUE_TOP)), random_bounds(255), random_bounds(255),
                   random_bounds(int'(HUE_TOP)), random_bounds(255), random_bounds(255));
    endtask

    task automatic run_random(input int count);
        int    mode;
        int    pick;
        int    base;
        t_chan b, g, r;
        repeat (count) begin
            mode = $urandom_range(0, 9);
            b = t_chan'($urandom_range(0, 255));
            g = t_chan'($urandom_range(0, 255));
            r = t_chan'($urandom_range(0, 255));
            if (mode >= 6 && mode <= 7) begin
                // two channels equal, exercises the tie order
                pick = $urandom_range(0, 2);
                if (pick == 0) g = r;
                else if (pick == 1) b = g;
                else b = r;
            end else if (mode == 8) begin
                g = b;
                r = b;
            end else if (mode == 9) begin
                // near grey, small diff
                base = $urandom_range(3, 252);
                b = t_chan'(base + $urandom_range(0, 6) - 3);
                g = t_chan'(base + $urandom_range(0, 6) - 3);
                r = t_chan'(base + $urandom_range(0, 6) - 3);
            end
            send_pixel(b, g, r);
        end
    endtask

    logic [3*CHAN_W-1:0] corner_px [22] = '{
        24'h000000, 24'hFFFFFF, 24'h4D4D4D, 24'h0000FF, 24'h00FF00, 24'hFF0000,
        24'h00FFFF, 24'hFFFF00, 24'hFF00FF, 24'h010000, 24'h800101, 24'h0A00C8,
        24'h0100FF, 24'h55AA55, 24'hAA55AA, 24'h807F80, 24'h7F807F, 24'h01FE01,
        24'hFE01FE, 24'h123456, 24'hFEDCBA, 24'h010101
    };

    initial begin
        tracker       = new();
        idling        = 1'b1;
        stall_left    = 0;
        cycle_count   = 0;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_blue_level  <= '0;
        i_green_level <= '0;
        i_red_level   <= '0;
        i_out_ready   <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // both boxes empty out of reset, nothing flagged
        run_random(40);
        drain_pipe();

        load_boxes(16'h5523, 16'hFF28, 16'hFF28, 16'h1905, 16'hFF32, 16'hC814);
        foreach (corner_px[i])
            send_pixel(corner_px[i][23:16], corner_px[i][15:8], corner_px[i][7:0]);
        run_random(200);
        // hold the sender until the pipe is empty
        drain_pipe();
        run_random(40);
        drain_pipe();

        load_boxes(16'hFF00, 16'hFF00, 16'hFF00, 16'hFF00, 16'hFF00, 16'hFF00);
        run_random(200);
        drain_pipe();

        load_boxes(16'h0000, 16'hFF00, 16'hFF00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(200);
        drain_pipe();

        idling = 1'b0;
        load_random_boxes();
        run_random(200);
        drain_pipe();

        idling = 1'b1;
        repeat (2) begin
            load_random_boxes();
            run_random(200);
            drain_pipe();
        end

        idling = 1'b0;
        load_boxes(16'h5523, 16'hFF28, 16'hFF28, 16'h1905, 16'hFF32, 16'hC814);
        run_random(200);
        drain_pipe();

        if (tracker.mismatches == 0 && tracker.words_pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/hsvc_pkg.sv
rtl/core/hsvc_recip_rom.sv
rtl/core/hsv_color_range_classifier_core.sv
bench/hsv_color_range_classifier_core_tb.sv
